@@ design/dts_pkg.sv @@
// Types, codes and constants for the debug transfer splitter.
// No dependencies; imported by debug_transfer_splitter.
package dts_pkg;

    // Input word opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Descriptor kinds on the output tuser
    typedef enum logic [2:0] {
        CMD_BARRIER      = 3'd0,
        CMD_SET_PAGE     = 3'd1,
        CMD_BULK_WRITE   = 3'd2,
        CMD_BULK_READ    = 3'd3,
        CMD_VOL_PREPARE  = 3'd4,
        CMD_VOL_EXECUTE  = 3'd5,
        CMD_COMPLETION   = 3'd6,
        CMD_INVALID_SIZE = 3'd7
    } t_cmd_kind;

    // Shape of the descriptor burst held for one input word
    typedef enum logic [2:0] {
        BURST_INVALID    = 3'd0,
        BURST_PAGE_WRITE = 3'd1,
        BURST_BULK_WRITE = 3'd2,
        BURST_BULK_READ  = 3'd3,
        BURST_VOLATILE   = 3'd4
    } t_burst;

    // Write data forms
    localparam logic [1:0] PAT_WORD = 2'd0;
    localparam logic [1:0] PAT_HALF = 2'd1;
    localparam logic [1:0] PAT_BYTE = 2'd2;

    // Lane flags: byte enables in the high nibble, bit 3 marks a write
    localparam logic [7:0] FLAGS_WORD    = 8'hF8;
    localparam logic [7:0] FLAGS_HALF_HI = 8'h38;
    localparam logic [7:0] FLAGS_HALF_LO = 8'hC8;
    localparam logic [3:0] FLAG_WRITE    = 4'h8;
    localparam logic [3:0] LANE_BYTE0    = 4'h8;

    localparam logic [31:0] PAGE_MASK  = 32'hFFFF_F000;
    localparam logic [31:0] WORD_MASK  = 32'hFFFF_FFFC;
    localparam logic [10:0] PAGE_WORDS = 11'd1024;
    localparam logic [2:0]  BULK_MAX_WORDS = 3'd7;
    localparam logic [12:0] BULK_MIN_BYTES = 13'd8;
    localparam logic [12:0] BULK_FULL_LIMIT = 13'd32;

    // Word offset / 7 as (x * 1171) >> 13, exact for x < 1024
    localparam logic [20:0] RECIP_7 = 21'd1171;
    localparam int          RECIP_SHIFT = 13;

    // Descriptors in a burst, completion included
    function automatic logic [2:0] burst_len(input t_burst cls, input logic done);
        logic [2:0] n;
        case (cls)
            BURST_INVALID:    n = 3'd1;
            BURST_PAGE_WRITE: n = 3'd4;
            BURST_BULK_WRITE: n = 3'd1;
            BURST_BULK_READ:  n = 3'd1;
            BURST_VOLATILE:   n = 3'd5;
            default:          n = 3'd1;
        endcase
        return n + {2'b00, done};
    endfunction

    // Kind of descriptor number idx within a burst
    function automatic t_cmd_kind kind_at(input t_burst cls, input logic done,
                                          input logic [2:0] idx, input logic [2:0] cnt);
        t_cmd_kind k;
        if (done && idx == cnt - 3'd1) begin
            k = CMD_COMPLETION;
        end else begin
            case (cls)
                BURST_INVALID:    k = CMD_INVALID_SIZE;
                BURST_PAGE_WRITE: k = (idx == 3'd1) ? CMD_SET_PAGE :
                                      (idx == 3'd3) ? CMD_BULK_WRITE : CMD_BARRIER;
                BURST_BULK_WRITE: k = CMD_BULK_WRITE;
                BURST_BULK_READ:  k = CMD_BULK_READ;
                BURST_VOLATILE:   k = (idx == 3'd1) ? CMD_VOL_PREPARE :
                                      (idx == 3'd3) ? CMD_VOL_EXECUTE : CMD_BARRIER;
                default:          k = CMD_BARRIER;
            endcase
        end
        return k;
    endfunction

endpackage

@@ design/debug_transfer_splitter.sv @@
// Debug transfer splitter: cuts debug read/write requests into bus descriptors.
// Depends on dts_pkg.
//
// A start word loads a request (read or write, address, byte count); each advance word
// cuts the next chunk off it and yields a burst of descriptors. Writes go as bulk runs
// of up to seven words when the page offset sits on a 28-byte block and at least 8 bytes
// remain (with barrier / set page / barrier first when the page changes), else as single
// volatile word, halfword or byte accesses. Reads go as bulk runs when word aligned with
// at least 8 bytes left, else as volatile word reads. Bulk runs stop at 4 KB page ends.
// The chunk that finishes the transfer appends a completion. A start with a count of 0
// or above MAX_BYTES yields one invalid size descriptor; an advance while idle is dropped.
// Timing: an input word is registered in the input register, then worked out into the
// burst register once that is free; the burst is played out one descriptor per cycle
// while m_axis_tready is high. The first descriptor is offered once the word is loaded.
// The output port sets the pace: an advance yields 1 to 6 descriptors; a valid start or
// an idle advance yields none but still takes a load, after which the output is idle.
// The next word is loaded in the cycle the last descriptor of the previous burst is taken.
module debug_transfer_splitter
    import dts_pkg::*;
#(
    parameter int MAX_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // is_write[0], start_address[32:1], byte_count[48:33]
    input  logic        s_axis_tuser,  // opcode
    // descriptors
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // bus_address[31:0], block_index[39:32],
                                       // end_address_low[47:40], word_count[50:48],
                                       // lane_flags[58:51], lane_pattern[60:59],
                                       // buffer_offset[72:61], used_bytes[77:73]
    output logic [2:0]  m_axis_tuser,  // cmd_kind
    output logic        m_axis_tlast
);

    localparam int BL_W = $clog2(MAX_BYTES + 1);

    // ---- input register ----
    logic        r_in_valid;
    logic        r_in_op;
    logic        r_in_write;
    logic [31:0] r_in_addr;
    logic [15:0] r_in_count;

    // ---- transfer state ----
    logic            r_busy;
    logic            r_write_mode;
    logic [31:0]     r_cur_addr;
    logic [BL_W-1:0] r_bytes_left;
    logic [11:0]     r_data_off;
    logic            r_page_known;
    logic [19:0]     r_sel_page;

    // ---- burst register ----
    logic        r_b_valid;
    t_burst      r_b_class;
    logic        r_b_done;
    logic [2:0]  r_b_cnt;
    logic [2:0]  r_b_idx;
    logic [31:0] r_b_addr;
    logic [7:0]  r_b_block;
    logic [7:0]  r_b_end;
    logic [2:0]  r_b_words;
    logic [7:0]  r_b_flags;
    logic [1:0]  r_b_pat;
    logic [11:0] r_b_off;
    logic [4:0]  r_b_used;

    logic load;
    logic b_last;
    logic b_last_taken;

    assign b_last       = (r_b_idx == r_b_cnt - 3'd1);
    assign b_last_taken = r_b_valid && m_axis_tready && b_last;
    assign load         = r_in_valid && (!r_b_valid || b_last_taken);
    assign s_axis_tready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op    <= s_axis_tuser;
            r_in_write <= s_axis_tdata[0];
            r_in_addr  <= s_axis_tdata[32:1];
            r_in_count <= s_axis_tdata[48:33];
        end
    end

    // ---- chunk arithmetic ----
    logic [12:0] c_rem;
    logic [11:0] c_off;
    logic [9:0]  c_wo;
    logic [20:0] c_prod;
    logic [7:0]  c_q;
    logic [10:0] c_q7;
    logic        c_on_block;
    logic [2:0]  c_nw_rem;
    logic [10:0] c_lim;
    logic [2:0]  c_nw;
    logic [2:0]  c_rd_span;
    logic        c_page_new;
    logic        c_start_ok;

    // burst being formed
    logic        g_has;
    t_burst      g_class;
    logic        g_done;
    logic [31:0] g_addr;
    logic [7:0]  g_end;
    logic [7:0]  g_flags;
    logic [1:0]  g_pat;
    logic [4:0]  g_used;
    logic        g_adv;
    logic        g_start;
    logic        g_set_page;
    logic [12:0] g_next_rem;

    assign c_rem   = 13'(r_bytes_left);
    assign c_off   = r_cur_addr[11:0];
    assign c_wo    = c_off[11:2];
    assign c_prod  = 21'(c_wo) * RECIP_7;
    assign c_q     = c_prod[RECIP_SHIFT +: 8];
    assign c_q7    = {c_q, 3'b000} - 11'(c_q);
    assign c_on_block = (c_off[1:0] == 2'b00) && (c_q7 == 11'(c_wo));
    assign c_nw_rem = (c_rem > BULK_FULL_LIMIT) ? BULK_MAX_WORDS
                                                : 3'((c_rem - 13'd4) >> 2);
    assign c_lim   = PAGE_WORDS - 11'(c_wo);
    assign c_nw    = (11'(c_nw_rem) > c_lim) ? c_lim[2:0] : c_nw_rem;
    assign c_rd_span = 3'd4 - {1'b0, r_cur_addr[1:0]};
    assign c_page_new = !r_page_known || (r_cur_addr[31:12] != r_sel_page);
    assign c_start_ok = (r_in_count != 16'd0) && (r_in_count <= 16'(MAX_BYTES));

    always_comb begin
        g_has      = 1'b0;
        g_class    = BURST_INVALID;
        g_addr     = '0;
        g_end      = '0;
        g_flags    = '0;
        g_pat      = PAT_WORD;
        g_used     = '0;
        g_adv      = 1'b0;
        g_start    = 1'b0;
        g_set_page = 1'b0;
        if (r_in_op == OP_START) begin
            if (c_start_ok) begin
                g_start = 1'b1;
            end else begin
                g_has = 1'b1;
            end
        end else if (r_busy) begin
            g_has = 1'b1;
            g_adv = 1'b1;
            if (r_write_mode && c_on_block && c_rem >= BULK_MIN_BYTES) begin
                g_class    = c_page_new ? BURST_PAGE_WRITE : BURST_BULK_WRITE;
                g_set_page = c_page_new;
                g_addr     = r_cur_addr & PAGE_MASK;
                g_used     = {c_nw, 2'b00};
            end else if (!r_write_mode && r_cur_addr[1:0] == 2'b00
                         && c_rem >= BULK_MIN_BYTES) begin
                g_class = BURST_BULK_READ;
                g_addr  = r_cur_addr;
                g_end   = r_cur_addr[7:0] + {3'b000, c_nw, 2'b00};
                g_used  = {c_nw, 2'b00};
            end else begin
                g_class = BURST_VOLATILE;
                g_addr  = r_cur_addr & WORD_MASK;
                if (r_write_mode) begin
                    if (r_cur_addr[1:0] == 2'b00 && c_rem >= 13'd4) begin
                        g_used  = 5'd4;
                        g_flags = FLAGS_WORD;
                        g_pat   = PAT_WORD;
                    end else if (!r_cur_addr[0] && c_rem >= 13'd2) begin
                        g_used  = 5'd2;
                        g_flags = r_cur_addr[1] ? FLAGS_HALF_HI : FLAGS_HALF_LO;
                        g_pat   = PAT_HALF;
                    end else begin
                        g_used  = 5'd1;
                        g_flags = {LANE_BYTE0 >> r_cur_addr[1:0], FLAG_WRITE};
                        g_pat   = PAT_BYTE;
                    end
                end else begin
                    g_used = (c_rem < 13'(c_rd_span)) ? 5'(c_rem) : 5'(c_rd_span);
                end
            end
        end
        g_next_rem = c_rem - 13'(g_used);
        g_done     = g_adv && (g_next_rem == 13'd0);
    end

    // ---- transfer state update ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_write_mode <= 1'b0;
            r_cur_addr   <= '0;
            r_bytes_left <= '0;
            r_data_off   <= '0;
            r_page_known <= 1'b0;
            r_sel_page   <= '0;
        end else if (load) begin
            if (g_start) begin
                r_busy       <= 1'b1;
                r_write_mode <= r_in_write;
                r_cur_addr   <= r_in_addr;
                r_bytes_left <= BL_W'(r_in_count);
                r_data_off   <= '0;
                r_page_known <= 1'b0;
            end else if (g_adv) begin
                r_cur_addr   <= r_cur_addr + 32'(g_used);
                r_bytes_left <= BL_W'(g_next_rem);
                r_data_off   <= r_data_off + 12'(g_used);
                if (g_done) begin
                    r_busy <= 1'b0;
                end
                if (g_set_page) begin
                    r_page_known <= 1'b1;
                    r_sel_page   <= r_cur_addr[31:12];
                end
            end
        end
    end

    // ---- burst register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_idx   <= '0;
        end else if (load) begin
            r_b_valid <= g_has;
            r_b_idx   <= '0;
        end else if (b_last_taken) begin
            r_b_valid <= 1'b0;
        end else if (r_b_valid && m_axis_tready) begin
            r_b_idx   <= r_b_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_b_class <= g_class;
            r_b_done  <= g_done;
            r_b_cnt   <= burst_len(g_class, g_done);
            r_b_addr  <= g_addr;
            r_b_block <= c_q;
            r_b_end   <= g_end;
            r_b_words <= c_nw;
            r_b_flags <= g_flags;
            r_b_pat   <= g_pat;
            r_b_off   <= g_adv ? r_data_off : 12'd0;
            r_b_used  <= g_used;
        end
    end

    // ---- descriptor output ----
    t_cmd_kind o_kind;

    always_comb begin
        o_kind       = kind_at(r_b_class, r_b_done, r_b_idx, r_b_cnt);
        m_axis_tdata = '0;
        if (o_kind == CMD_SET_PAGE || o_kind == CMD_BULK_READ || o_kind == CMD_VOL_PREPARE) begin
            m_axis_tdata[31:0] = r_b_addr;
        end
        if (o_kind == CMD_BULK_WRITE) begin
            m_axis_tdata[39:32] = r_b_block;
        end
        if (o_kind == CMD_BULK_READ) begin
            m_axis_tdata[47:40] = r_b_end;
        end
        if (o_kind == CMD_BULK_WRITE || o_kind == CMD_BULK_READ) begin
            m_axis_tdata[50:48] = r_b_words;
        end
        if (o_kind == CMD_VOL_PREPARE) begin
            m_axis_tdata[58:51] = r_b_flags;
            m_axis_tdata[60:59] = r_b_pat;
        end
        m_axis_tdata[72:61] = r_b_off;
        m_axis_tdata[77:73] = r_b_used;
    end

    assign m_axis_tvalid = r_b_valid;
    assign m_axis_tuser  = o_kind;
    assign m_axis_tlast  = b_last;

    // ---- checks ----
    a_idx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_idx < r_b_cnt))
        else $error("descriptor index past burst length");

    a_busy_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_bytes_left != '0))
        else $error("busy flag and bytes left disagree");

    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        13'(r_bytes_left) <= 13'(MAX_BYTES))
        else $error("bytes left above maximum");

    a_completion_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && (o_kind == CMD_COMPLETION || o_kind == CMD_INVALID_SIZE))
            |-> m_axis_tlast)
        else $error("completion or invalid size not final in burst");

    a_done_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && g_done) |=> !r_busy)
        else $error("finished transfer still busy");

endmodule

@@ verif/tb_debug_transfer_splitter.sv @@
// Self-checking testbench for debug_transfer_splitter: directed table, then random transfers.
// Predicts every descriptor burst at word acceptance and checks the output stream in order.
// Depends on dts_pkg and debug_transfer_splitter.
`timescale 1ns / 100ps

module tb_debug_transfer_splitter;
    import dts_pkg::*;

    localparam int DTS_MAX_BYTES = 4096;
    localparam int NUM_DIR       = 25;
    localparam int RANDOM_WORDS  = 375;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int MAX_REPORTS   = 10;

    // How the expectation of a table row is obtained
    typedef enum logic [1:0] {
        CHK_MODEL    = 2'd0,  // worked out by the predictor
        CHK_NONE     = 2'd1,  // typed in: no descriptor at all
        CHK_SIZE_ERR = 2'd2   // typed in: a lone invalid size descriptor
    } t_check;

    typedef struct packed {
        logic        op;
        logic        wr;
        logic [31:0] addr;
        logic [15:0] cnt;
        t_check      chk;
    } t_row;

    // One descriptor, as seen on the output stream
    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] bus_address;
        logic [7:0]  block_index;
        logic [7:0]  end_low;
        logic [2:0]  word_count;
        logic [7:0]  lane_flags;
        logic [1:0]  lane_pattern;
        logic [11:0] buf_off;
        logic [4:0]  used;
        logic        last;
    } t_desc;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;   // is_write, start_address, byte_count
    logic        s_axis_tuser = OP_START;  // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;       // bus_address, block_index, end_address_low,
                                     // word_count, lane_flags, lane_pattern,
                                     // buffer_offset, used_bytes
    logic [2:0]  m_axis_tuser;       // cmd_kind
    logic        m_axis_tlast;

    // Descriptors still owed by the block, oldest first
    t_desc descr_due[$];

    // Predictor's copy of the transfer state
    logic        pend_busy;
    logic        pend_write;
    logic [31:0] pend_addr;
    logic [12:0] pend_left;
    logic [11:0] pend_off;
    logic        page_valid;
    logic [19:0] page_sel;
    logic [11:0] chunk_off;
    int          chunk_used;

    int  n_errors = 0;
    int  words_sent = 0;
    int  cycle_cnt = 0;
    int  rx_stall_left = 0;
    bit  quiet_tx = 1'b0;
    bit  quiet_rx = 1'b0;

    // Directed part: reset, size errors, extremes, each access form
    t_row dir_rows [NUM_DIR] = '{
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_NONE},      // advance while idle
        '{OP_START,   1'b0, 32'h0000_0000, 16'd0,    CHK_SIZE_ERR},  // zero count
        '{OP_START,   1'b1, 32'h1234_5678, 16'd4097, CHK_SIZE_ERR},  // just over max
        '{OP_START,   1'b1, 32'hFFFF_FFFF, 16'hFFFF, CHK_SIZE_ERR},  // all ones
        '{OP_START,   1'b1, 32'h0000_0000, 16'd40,   CHK_MODEL},     // bulk writes, page set
        '{OP_ADVANCE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, CHK_MODEL},
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL},
        '{OP_ADVANCE, 1'b1, 32'hA5A5_A5A5, 16'h5A5A, CHK_MODEL},
        '{OP_START,   1'b1, 32'hFFFF_FFFD, 16'd7,    CHK_MODEL},     // byte, half, wrap, word
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL},
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL},
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL},
        '{OP_START,   1'b0, 32'h0000_0FF0, 16'd20,   CHK_MODEL},     // bulk read to page end
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL},
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL},
        '{OP_START,   1'b0, 32'h0000_0013, 16'd2,    CHK_MODEL},     // unaligned short read
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL},
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL},
        '{OP_START,   1'b1, 32'h1234_5FF8, 16'd12,   CHK_MODEL},     // last block of page
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL},
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL},
        '{OP_START,   1'b1, 32'h0000_0000, 16'd4096, CHK_MODEL},     // largest write
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL},
        '{OP_START,   1'b0, 32'h8000_0000, 16'd4096, CHK_MODEL},     // abandons the write
        '{OP_ADVANCE, 1'b0, 32'h0000_0000, 16'd0,    CHK_MODEL}
    };

    debug_transfer_splitter #(
        .MAX_BYTES(DTS_MAX_BYTES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Words in a bulk run: at most seven, at least a word left over, never past the page end
    function automatic int bulk_words(int rem, int poff);
        int nw;
        int lim;
        nw  = (rem > 32) ? 7 : (rem - 4) / 4;
        lim = (4096 - poff) / 4;
        return (nw > lim) ? lim : nw;
    endfunction

    function automatic t_desc blank_desc(t_cmd_kind kind);
        t_desc d;
        d         = '0;
        d.kind    = kind;
        d.buf_off = chunk_off;
        d.used    = chunk_used[4:0];
        return d;
    endfunction

    function automatic string desc_text(t_desc d);
        return {$sformatf("kind=%0d addr=%h blk=%0d end=%h wc=%0d ", d.kind, d.bus_address,
                          d.block_index, d.end_low, d.word_count),
                $sformatf("flg=%h pat=%0d off=%0d used=%0d last=%0b", d.lane_flags,
                          d.lane_pattern, d.buf_off, d.used, d.last)};
    endfunction

    function automatic void reset_splitter_state();
        pend_busy  = 1'b0;
        pend_write = 1'b0;
        pend_addr  = '0;
        pend_left  = '0;
        pend_off   = '0;
        page_valid = 1'b0;
        page_sel   = '0;
        chunk_off  = '0;
        chunk_used = 0;
    endfunction

    // Works out the descriptor burst of one accepted word and queues it
    function automatic void predict_word(logic op, logic wr, logic [31:0] addr,
                                         logic [15:0] cnt);
        t_desc       burst[$];
        t_desc       d;
        logic [31:0] a;
        logic [12:0] rem;
        logic [11:0] poff;
        logic [7:0]  flags;
        logic [1:0]  pat;
        int          nw;
        int          used;
        if (op == OP_START) begin
            if (cnt == 0 || cnt > DTS_MAX_BYTES) begin
                chunk_off  = '0;
                chunk_used = 0;
                burst.push_back(blank_desc(CMD_INVALID_SIZE));
            end else begin
                pend_busy  = 1'b1;
                pend_write = wr;
                pend_addr  = addr;
                pend_left  = cnt[12:0];
                pend_off   = '0;
                page_valid = 1'b0;
            end
        end else if (pend_busy) begin
            a         = pend_addr;
            rem       = pend_left;
            poff      = a[11:0];
            chunk_off = pend_off;
            if (pend_write && (poff % 28) == 0 && rem >= 8) begin
                nw         = bulk_words(int'(rem), int'(poff));
                chunk_used = nw * 4;
                // page switch is fenced by barriers on both sides
                if (!page_valid || a[31:12] != page_sel) begin
                    burst.push_back(blank_desc(CMD_BARRIER));
                    d             = blank_desc(CMD_SET_PAGE);
                    d.bus_address = a & PAGE_MASK;
                    burst.push_back(d);
                    burst.push_back(blank_desc(CMD_BARRIER));
                    page_valid = 1'b1;
                    page_sel   = a[31:12];
                end
                d             = blank_desc(CMD_BULK_WRITE);
                d.block_index = 8'(poff / 28);
                d.word_count  = nw[2:0];
                burst.push_back(d);
            end else if (!pend_write && a[1:0] == 2'b00 && rem >= 8) begin
                nw            = bulk_words(int'(rem), int'(poff));
                chunk_used    = nw * 4;
                d             = blank_desc(CMD_BULK_READ);
                d.bus_address = a;
                d.end_low     = a[7:0] + 8'(nw * 4);
                d.word_count  = nw[2:0];
                burst.push_back(d);
            end else begin
                flags = '0;
                pat   = PAT_WORD;
                if (pend_write) begin
                    if (a[1:0] == 2'b00 && rem >= 4) begin
                        used  = 4;
                        flags = FLAGS_WORD;
                    end else if (!a[0] && rem >= 2) begin
                        used  = 2;
                        flags = a[1] ? FLAGS_HALF_HI : FLAGS_HALF_LO;
                        pat   = PAT_HALF;
                    end else begin
                        used  = 1;
                        flags = {LANE_BYTE0 >> a[1:0], FLAG_WRITE};
                        pat   = PAT_BYTE;
                    end
                end else begin
                    // read up to the next word boundary, or what is left
                    used = 4 - int'(a[1:0]);
                    if (int'(rem) < used) used = int'(rem);
                end
                chunk_used = used;
                burst.push_back(blank_desc(CMD_BARRIER));
                d              = blank_desc(CMD_VOL_PREPARE);
                d.bus_address  = a & WORD_MASK;
                d.lane_flags   = flags;
                d.lane_pattern = pat;
                burst.push_back(d);
                burst.push_back(blank_desc(CMD_BARRIER));
                burst.push_back(blank_desc(CMD_VOL_EXECUTE));
                burst.push_back(blank_desc(CMD_BARRIER));
            end
            pend_addr = a + 32'(chunk_used);
            pend_left = rem - 13'(chunk_used);
            pend_off  = pend_off + 12'(chunk_used);
            if (pend_left == 0) begin
                burst.push_back(blank_desc(CMD_COMPLETION));
                pend_busy = 1'b0;
            end
        end
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) descr_due.push_back(burst[i]);
    endfunction

    function automatic void note_error(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Presents one word, waits for it to be taken, then records what it should cause
    task automatic send_word(input logic op, input logic wr, input logic [31:0] addr,
                             input logic [15:0] cnt, input t_check chk);
        int    gap;
        logic  was_busy;
        t_desc d;
        gap           = quiet_tx ? 0 : pick_gap();
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge i_clk);
        s_axis_tdata  = {7'd0, cnt, addr, wr};
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        was_busy = pend_busy;
        case (chk)
            CHK_MODEL: predict_word(op, wr, addr, cnt);
            CHK_SIZE_ERR: begin
                d      = '0;
                d.kind = CMD_INVALID_SIZE;
                d.last = 1'b1;
                descr_due.push_back(d);
            end
            default: ;
        endcase
        // an advance with nothing pending is dropped and does not count
        if (op == OP_START || was_busy) words_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (descr_due.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_address();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2: return $urandom;
            3, 4, 5: return {20'($urandom_range(0, 20'hFFFFF)),
                             12'(28 * $urandom_range(0, 146))};
            6:       return {20'($urandom_range(0, 20'hFFFFF)),
                             12'(12'hFFF - $urandom_range(0, 48))};
            7:       return 32'hFFFF_FFFF - $urandom_range(0, 64);
            default: return $urandom & WORD_MASK;
        endcase
    endfunction

    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(1, 40));
        if (r < 97) return 16'($urandom_range(41, 300));
        return 16'($urandom_range(1, DTS_MAX_BYTES));
    endfunction

    // Sink side: ready drops for random stretches, with quiet spells
    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!quiet_rx && $urandom_range(0, 3) == 0) rx_stall_left <= pick_gap();
        end
    end

    // Output check: every taken descriptor against the oldest one owed
    always @(posedge i_clk) begin
        t_desc got;
        t_desc want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind         = t_cmd_kind'(m_axis_tuser);
            got.bus_address  = m_axis_tdata[31:0];
            got.block_index  = m_axis_tdata[39:32];
            got.end_low      = m_axis_tdata[47:40];
            got.word_count   = m_axis_tdata[50:48];
            got.lane_flags   = m_axis_tdata[58:51];
            got.lane_pattern = m_axis_tdata[60:59];
            got.buf_off      = m_axis_tdata[72:61];
            got.used         = m_axis_tdata[77:73];
            got.last         = m_axis_tlast;
            if (descr_due.size() == 0) begin
                note_error({"unexpected descriptor ", desc_text(got)});
            end else begin
                want = descr_due.pop_front();
                if (got !== want)
                    note_error({"descriptor mismatch\n  exp ", desc_text(want),
                                "\n  got ", desc_text(got)});
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int          r;
        int          n_adv;
        int          stop_at;
        bit          abandon;
        reset_splitter_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < NUM_DIR; i++)
            send_word(dir_rows[i].op, dir_rows[i].wr, dir_rows[i].addr, dir_rows[i].cnt,
                      dir_rows[i].chk);

        // hold off until the directed bursts have all drained
        wait_drained();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 19) == 0) quiet_tx = ~quiet_tx;
            if ($urandom_range(0, 19) == 0) quiet_rx = ~quiet_rx;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // size error, zero or oversized
                send_word(OP_START, 1'($urandom_range(0, 1)), $urandom,
                          ($urandom_range(0, 2) == 0) ? 16'd0
                              : 16'($urandom_range(DTS_MAX_BYTES + 1, 65535)),
                          CHK_MODEL);
            end else if (r < 12) begin
                // stray advance with junk fields; dropped when idle
                send_word(OP_ADVANCE, 1'($urandom_range(0, 1)), $urandom, 16'($urandom),
                          CHK_MODEL);
            end else begin
                // well formed transfer, now and then cut short by a fresh start
                send_word(OP_START, 1'($urandom_range(0, 1)), pick_address(), pick_count(),
                          CHK_MODEL);
                abandon = ($urandom_range(0, 9) == 0);
                stop_at = $urandom_range(1, 8);
                n_adv   = 0;
                while (pend_busy && !(abandon && n_adv == stop_at)) begin
                    send_word(OP_ADVANCE, 1'($urandom_range(0, 1)), $urandom,
                              16'($urandom), CHK_MODEL);
                    n_adv++;
                end
            end
            if ($urandom_range(0, 29) == 0) wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (n_errors == 0 && descr_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
